>>> rtl/core/b64c_pkg.sv
`default_nettype none

package b64c_pkg;

   // Direction register codes.
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Base64 pad character and the marker for a character outside the alphabet.
   localparam logic [7:0] PAD_CHAR       = 8'h3D;
   localparam logic [6:0] INVALID_SEXTET = 7'd64;

   // Results one request can produce, and the width of a result index.
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned RESULT_IDX_W = $clog2(MAX_RESULTS);

   // Message state carried from one request to the next.
   typedef struct packed {
      logic [11:0] acc;
      logic [3:0]  cnt;
      logic [1:0]  cmf;
      logic        stopped;
   } codec_state_type;

   // All results produced by one request.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0]  bytes;
      logic [MAX_RESULTS-1:0]       has;
      logic [RESULT_IDX_W-1:0]      last_idx;
      logic                         eom;
   } result_bundle_type;

   // Alphabet character for a 6-bit value.
   function automatic logic [7:0] alphabet_char(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

   // 6-bit value of an alphabet character, or INVALID_SEXTET outside the alphabet.
   function automatic logic [6:0] sextet(input logic [7:0] c);
      logic [6:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 7'(c - 8'h61) + 7'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30) + 7'd52;
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end else begin
         v = INVALID_SEXTET;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/b64c_step.sv
`default_nettype none

// Combinational work for one request: produces up to four results and the
// message state that follows.
module b64c_step import b64c_pkg::*; (
   input  wire logic              direction,
   input  wire codec_state_type   state,
   input  wire logic [7:0]        data_byte,
   input  wire logic              end_of_message,
   output result_bundle_type      bundle,
   output logic                   emit,
   output codec_state_type        next_state
);

   logic [11:0]                  acc_v;
   logic [4:0]                   bc_v;
   logic [1:0]                   cmf_v;
   logic                         stop_v;
   logic [2:0]                   n_v;
   logic [MAX_RESULTS-1:0][7:0]  bytes_v;
   logic [MAX_RESULTS-1:0]       has_v;
   logic [6:0]                   sx_v;
   logic [7:0]                   ch_v;

   always_comb begin
      acc_v   = state.acc;
      bc_v    = {1'b0, state.cnt};
      cmf_v   = state.cmf;
      stop_v  = state.stopped;
      n_v     = 3'd0;
      bytes_v = '0;
      has_v   = '0;
      sx_v    = 7'd0;
      ch_v    = 8'd0;

      if (direction == DIR_ENCODE) begin
         // Append the byte, then emit every complete sextet.
         acc_v = {state.acc[3:0], data_byte};
         bc_v  = {1'b0, state.cnt} + 5'd8;
         for (int k = 0; k < 2; k++) begin
            if (bc_v >= 5'd6 && bc_v <= 5'd12) begin
               ch_v = alphabet_char(6'(acc_v >> (bc_v - 5'd6)));
               if (n_v < 3'd4) begin
                  bytes_v[n_v[1:0]] = ch_v;
                  has_v[n_v[1:0]]   = 1'b1;
                  n_v               = n_v + 3'd1;
               end
               cmf_v = cmf_v + 2'd1;
               bc_v  = bc_v - 5'd6;
               acc_v = acc_v & ((12'd1 << bc_v) - 12'd1);
            end
         end
         if (bc_v > 5'd12) begin
            bc_v = 5'd0;
         end
         if (end_of_message) begin
            // Flush the leftover bits as one more character.
            if (bc_v > 5'd0 && bc_v < 5'd6) begin
               ch_v = alphabet_char(6'(acc_v << (5'd6 - bc_v)));
               if (n_v < 3'd4) begin
                  bytes_v[n_v[1:0]] = ch_v;
                  has_v[n_v[1:0]]   = 1'b1;
                  n_v               = n_v + 3'd1;
               end
               cmf_v = cmf_v + 2'd1;
            end
            // Pad to a multiple of four characters.
            for (int k = 0; k < 3; k++) begin
               if (cmf_v != 2'd0 && n_v < 3'd4) begin
                  bytes_v[n_v[1:0]] = PAD_CHAR;
                  has_v[n_v[1:0]]   = 1'b1;
                  n_v               = n_v + 3'd1;
                  cmf_v             = cmf_v + 2'd1;
               end
            end
         end
      end else if (!state.stopped) begin
         // Decode one character; anything outside the alphabet stops decoding.
         sx_v = sextet(data_byte);
         if (sx_v == INVALID_SEXTET) begin
            stop_v = 1'b1;
         end else begin
            acc_v = {state.acc[5:0], sx_v[5:0]};
            bc_v  = {1'b0, state.cnt} + 5'd6;
            if (bc_v >= 5'd8 && bc_v <= 5'd12) begin
               bytes_v[0] = 8'(acc_v >> (bc_v - 5'd8));
               has_v[0]   = 1'b1;
               n_v        = 3'd1;
               bc_v       = bc_v - 5'd8;
               acc_v      = acc_v & ((12'd1 << bc_v) - 12'd1);
            end
            if (bc_v > 5'd12) begin
               bc_v = 5'd0;
            end
         end
      end

      // The last request always yields a result; an empty end marker if needed.
      if (end_of_message && n_v == 3'd0) begin
         n_v = 3'd1;
      end

      emit              = (n_v != 3'd0);
      bundle.bytes      = bytes_v;
      bundle.has        = has_v;
      bundle.last_idx   = RESULT_IDX_W'(n_v - 3'd1);
      bundle.eom        = end_of_message;

      if (end_of_message) begin
         next_state = '0;
      end else begin
         next_state.acc     = acc_v;
         next_state.cnt     = bc_v[3:0];
         next_state.cmf     = cmf_v;
         next_state.stopped = stop_v;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/b64c_out_buffer.sv
`default_nettype none

// Result register: holds the results of one request and sends them out one
// per cycle while rsp_tready is high.
module b64c_out_buffer import b64c_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load_valid,
   input  wire result_bundle_type  load_bundle,
   output logic                    load_ready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,   // out_byte[7:0]
   output logic                    rsp_tuser,   // has_byte
   output logic                    rsp_tlast    // out_last
);

   logic                     valid_ff, valid_in;
   logic [RESULT_IDX_W-1:0]  idx_ff, idx_in;
   result_bundle_type        bundle_ff, bundle_in;
   logic                     take;
   logic                     final_slot;
   logic                     drain;
   logic                     load;

   // Handshake bookkeeping.
   always_comb begin
      final_slot = (idx_ff == bundle_ff.last_idx);
      take       = valid_ff & rsp_tready;
      drain      = take & final_slot;
      load_ready = !valid_ff | drain;
      load       = load_valid & load_ready;
   end

   // Next buffer contents.
   always_comb begin
      valid_in  = valid_ff;
      idx_in    = idx_ff;
      bundle_in = bundle_ff;
      if (load) begin
         valid_in  = 1'b1;
         idx_in    = '0;
         bundle_in = load_bundle;
      end else if (drain) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + RESULT_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

   // Present the current result.
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bundle_ff.bytes[idx_ff];
   assign rsp_tuser  = bundle_ff.has[idx_ff];
   assign rsp_tlast  = bundle_ff.eom & final_slot;

endmodule

`default_nettype wire

>>> rtl/core/base64_stream_codec_unit.sv
`default_nettype none

// Streaming base64 codec with the standard alphabet, one message byte per
// request. The direction register picks encode (0) or decode (1); writing it
// also abandons any message in progress, so write it only between messages.
// A request waits in an input register until its results fit in a result
// register, and the next request is taken in the same cycle that it moves
// on; results go out one per cycle from the result register while the
// output is not stalled. Each request gives zero to four results (encode:
// one or two characters, plus flush and '=' padding on the last byte;
// decode: zero or one byte), so the output channel sets the sustained rate:
// about four results per three bytes when encoding, at most one per
// request when decoding. The last request of a message always gives a
// result with tlast set; tuser low marks an empty end marker. Decoding stops
// at the first character outside the alphabet, '=' included, until the
// message ends.
module base64_stream_codec_unit import b64c_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,   // direction
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,        // data_byte[7:0]
   input  wire logic        req_tlast,        // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,        // out_byte[7:0]
   output logic             rsp_tuser,        // has_byte
   output logic             rsp_tlast         // out_last
);

   logic               direction_ff, direction_in;
   codec_state_type    state_ff, state_in;
   logic               req_valid_ff, req_valid_in;
   logic [7:0]         req_byte_ff, req_byte_in;
   logic               req_eom_ff, req_eom_in;
   result_bundle_type  step_bundle;
   logic               step_emit;
   codec_state_type    step_state;
   logic               load_ready;
   logic               advance;

   b64c_step u_step (
      .direction      (direction_ff),
      .state          (state_ff),
      .data_byte      (req_byte_ff),
      .end_of_message (req_eom_ff),
      .bundle         (step_bundle),
      .emit           (step_emit),
      .next_state     (step_state)
   );

   b64c_out_buffer u_out_buffer (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (req_valid_ff & step_emit),
      .load_bundle (step_bundle),
      .load_ready  (load_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // The held request moves on when its results fit in the result register.
   assign advance    = req_valid_ff & (!step_emit | load_ready);
   assign req_tready = !req_valid_ff | advance;

   // Input register.
   always_comb begin
      req_valid_in = req_tready ? req_tvalid : req_valid_ff;
      req_byte_in  = req_byte_ff;
      req_eom_in   = req_eom_ff;
      if (req_tvalid && req_tready) begin
         req_byte_in = req_tdata;
         req_eom_in  = req_tlast;
      end
   end

   // Direction register and message state.
   always_comb begin
      direction_in = direction_ff;
      state_in     = state_ff;
      if (csr_write_enable) begin
         direction_in = csr_write_data;
         state_in     = '0;
      end else if (advance) begin
         state_in = step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         direction_ff <= DIR_ENCODE;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         direction_ff <= direction_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_byte_ff <= req_byte_in;
      req_eom_ff  <= req_eom_in;
   end

endmodule

`default_nettype wire
